/* hw/rtl/bcra_pkg.sv */
// bcra_pkg: shared types and constants of the bitmap run allocator
// depends on nothing; imported by every module of the block

package bcra_pkg;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 10;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;

  localparam int CAPACITY_BITS_DEF = 1024;
  localparam int WORD_BITS_DEF     = 32;

  localparam logic [LEN_W-1:0] BITS_IN_USE_RST = 11'd1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_RUN = 2'd1,
    STAT_RANGE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANGE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic fits;
    logic at_hi;
  } seek_t;

endpackage

/* hw/rtl/bcra_bitmap.sv */
// bcra_bitmap: word store of the usage bitmap, one write and one registered read a cycle
// per-word valid bits make unwritten words read as free; uses bcra_pkg

module bcra_bitmap
  import bcra_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int WORDS     = CAPACITY_BITS_DEF / WORD_BITS_DEF,
  parameter int AW        = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [WORD_BITS-1:0] wr_data_i
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     vld_q;
  logic [WORD_BITS-1:0] data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= (int'(rd_addr_i) < WORDS) && vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_vld_q ? data_q : '0;

endmodule

/* hw/rtl/bcra_seek.sv */
// bcra_seek: shared word evaluator, finds the next used and next free slot in a word
// and builds the range write mask; uses bcra_pkg

module bcra_seek
  import bcra_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int XW        = 12
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [XW-1:0]        pos_i,
  input  logic [XW-1:0]        cand_i,
  input  logic [XW-1:0]        hi_i,
  input  logic [XW-1:0]        len_i,
  output seek_t                flags_o,
  output logic [XW-1:0]        pos_next_o,
  output logic [XW-1:0]        cand_next_o,
  output logic [XW-1:0]        word_end_o,
  output logic [WORD_BITS-1:0] mask_o
);

  localparam int OW = $clog2(WORD_BITS);

  logic [OW-1:0]        off;
  logic [XW-1:0]        base;
  logic [XW-1:0]        q;
  logic [XW-1:0]        e;
  logic [XW-1:0]        nxt;
  logic [WORD_BITS-1:0] used_m;
  logic [WORD_BITS-1:0] free_m;
  logic                 q_has;
  logic                 z_has;
  logic [OW-1:0]        q_off;
  logic [OW-1:0]        z_off;

  always_comb begin
    off        = pos_i[OW-1:0];
    base       = {pos_i[XW-1:OW], {OW{1'b0}}};
    word_end_o = base + XW'(WORD_BITS);

    for (int i = 0; i < WORD_BITS; i++) begin
      used_m[i] = word_i[i] && (OW'(i) >= off);
      mask_o[i] = (OW'(i) >= off) && ((base + XW'(i)) < hi_i);
    end

    // first used slot at or after the scan position
    q_has = 1'b0;
    q_off = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (used_m[i]) begin
        q_has = 1'b1;
        q_off = OW'(i);
      end
    end

    // first free slot after that used slot
    for (int i = 0; i < WORD_BITS; i++) begin
      free_m[i] = !word_i[i] && (OW'(i) > q_off);
    end
    z_has = 1'b0;
    z_off = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_m[i]) begin
        z_has = 1'b1;
        z_off = OW'(i);
      end
    end

    q             = q_has ? (base + XW'(q_off)) : word_end_o;
    e             = (q < hi_i) ? q : hi_i;
    flags_o.fits  = (e >= cand_i) && ((e - cand_i) >= len_i);
    flags_o.at_hi = (q >= hi_i);

    nxt = z_has ? (base + XW'(z_off)) : word_end_o;
    if (q_has) begin
      pos_next_o  = nxt;
      cand_next_o = nxt;
    end else begin
      pos_next_o  = word_end_o;
      cand_next_o = cand_i;
    end
  end

endmodule

/* hw/rtl/bitmap_contiguous_run_allocator_unit.sv */
// bitmap_contiguous_run_allocator_unit: top level, request sequencer and result register
// depends on bcra_pkg, bcra_bitmap and bcra_seek
//
// usage:
//   request channel (in_valid_i / in_ready_o) carries opcode_i, start_index_i and
//   run_length_i; the result channel (out_valid_o / out_ready_i) returns status_o,
//   result_index_o and bit_value_o, one result per request, in order.
//   cfg_we_i / cfg_wdata_i write bits_in_use; write only while no request is open.
//   one request is worked at a time; in_ready_o is high only when the sequencer is idle.
//   states from accept to result valid, in order:
//     rejected request: result state, then output register; read bit: read state first
//     set / clear range: one range state per word the range touches, then as above
//     allocate: scan steps, then range states for the words of the run; a scan step covers one bitmap
//     word, plus one extra step per used stretch met inside a word
//   the bitmap word store has one read and one write port, which sets the top
//   one-word-per-cycle pace of scan and range writes.
//   a finished result sits in the output register; while the receiver stalls, a
//   next request may be accepted and worked, and its result waits for the slot.
//   reset clears every slot to free and sets bits_in_use to 1024 at once.

module bitmap_contiguous_run_allocator_unit
  import bcra_pkg::*;
#(
  parameter int CAPACITY_BITS = CAPACITY_BITS_DEF,
  parameter int WORD_BITS     = WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [INDEX_W-1:0]  start_index_i,
  input  logic [LEN_W-1:0]    run_length_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [INDEX_W-1:0]  result_index_o,
  output logic                bit_value_o,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_wdata_i
);

  localparam int IW    = $clog2(CAPACITY_BITS + 1);
  localparam int XW    = ((IW > LEN_W) ? IW : LEN_W) + 1;
  localparam int OW    = $clog2(WORD_BITS);
  localparam int WORDS = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY_BITS);

  state_e               state_q, state_d;
  logic [XW-1:0]        p_q, p_d;
  logic [XW-1:0]        c_q, c_d;
  logic [XW-1:0]        hi_q, hi_d;
  logic [XW-1:0]        len_q, len_d;
  logic                 set_q, set_d;
  status_e              status_q, status_d;
  logic [INDEX_W-1:0]   res_q, res_d;
  logic                 bit_q, bit_d;
  logic [LEN_W-1:0]     biu_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [INDEX_W-1:0]   out_index_q;
  logic                 out_bit_q;

  logic                 in_acc;
  logic                 resp_load;
  op_e                  op;
  logic [XW-1:0]        biu_x;
  logic [XW-1:0]        lim_x;
  logic [XW-1:0]        start_x;
  logic [XW-1:0]        len_x;
  logic [XW-1:0]        end_x;
  logic                 start_bad;
  logic                 len_bad;

  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  seek_t                flags;
  logic [XW-1:0]        pos_next;
  logic [XW-1:0]        cand_next;
  logic [XW-1:0]        word_end;
  logic [WORD_BITS-1:0] mask;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign resp_load  = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  assign op        = op_e'(opcode_i);
  assign biu_x     = XW'(biu_q);
  assign lim_x     = (biu_x > CAP_X) ? CAP_X : biu_x;
  assign start_x   = XW'(start_index_i);
  assign len_x     = XW'(run_length_i);
  assign end_x     = ((start_x + len_x) < lim_x) ? (start_x + len_x) : lim_x;
  assign start_bad = (start_x >= lim_x);
  assign len_bad   = (len_x == '0) || (len_x > CAP_X);

  bcra_bitmap #(
    .WORD_BITS (WORD_BITS),
    .WORDS     (WORDS),
    .AW        (AW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (p_d[OW +: AW]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (p_q[OW +: AW]),
    .wr_data_i (wr_data)
  );

  bcra_seek #(
    .WORD_BITS (WORD_BITS),
    .XW        (XW)
  ) u_seek (
    .word_i      (rd_data),
    .pos_i       (p_q),
    .cand_i      (c_q),
    .hi_i        (hi_q),
    .len_i       (len_q),
    .flags_o     (flags),
    .pos_next_o  (pos_next),
    .cand_next_o (cand_next),
    .word_end_o  (word_end),
    .mask_o      (mask)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (start_bad) begin
            state_d = ST_RESP;
          end else if (op == OP_READ) begin
            state_d = ST_READ;
          end else if (len_bad) begin
            state_d = ST_RESP;
          end else if (op == OP_ALLOC) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RANGE;
          end
        end
      end
      ST_SCAN: begin
        if (flags.fits) begin
          state_d = ST_RANGE;
        end else if (flags.at_hi) begin
          state_d = ST_RESP;
        end
      end
      ST_RANGE: begin
        if (word_end >= hi_q) begin
          state_d = ST_RESP;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (resp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    p_d      = p_q;
    c_d      = c_q;
    hi_d     = hi_q;
    len_d    = len_q;
    set_d    = set_q;
    status_d = status_q;
    res_d    = res_q;
    bit_d    = bit_q;
    wr_en    = 1'b0;
    wr_data  = set_q ? (rd_data | mask) : (rd_data & ~mask);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          p_d      = start_x;
          c_d      = start_x;
          len_d    = len_x;
          set_d    = (op != OP_CLEAR);
          res_d    = start_index_i;
          bit_d    = 1'b0;
          hi_d     = (op == OP_ALLOC) ? lim_x : end_x;
          status_d = (start_bad || ((op != OP_READ) && len_bad)) ? STAT_RANGE : STAT_OK;
        end
      end
      ST_SCAN: begin
        if (flags.fits) begin
          p_d   = c_q;
          hi_d  = c_q + len_q;
          res_d = c_q[INDEX_W-1:0];
        end else if (flags.at_hi) begin
          status_d = STAT_NO_RUN;
        end else begin
          p_d = pos_next;
          c_d = cand_next;
        end
      end
      ST_RANGE: begin
        wr_en = 1'b1;
        p_d   = word_end;
      end
      ST_READ: begin
        bit_d = rd_data[p_q[OW-1:0]];
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      biu_q       <= BITS_IN_USE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        biu_q <= cfg_wdata_i;
      end
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    c_q      <= c_d;
    hi_q     <= hi_d;
    len_q    <= len_d;
    set_q    <= set_d;
    status_q <= status_d;
    res_q    <= res_d;
    bit_q    <= bit_d;
    if (resp_load) begin
      out_status_q <= status_q;
      out_index_q  <= res_q;
      out_bit_q    <= bit_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_index_o = out_index_q;
  assign bit_value_o    = out_bit_q;

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking bench for the first-fit bitmap run allocator
// drives random and directed requests, predicts each result from a private
// copy of the slot bitmap; depends on bcra_pkg and bitmap_contiguous_run_allocator_unit
`timescale 1ns / 1ps

module tb_top;
  import bcra_pkg::*;

  localparam int CAP         = CAPACITY_BITS_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    op_e                op;
    logic [INDEX_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] index;
    logic               bit_val;
  } reply_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [OPCODE_W-1:0] opcode_i      = '0;
  logic [INDEX_W-1:0]  start_index_i = '0;
  logic [LEN_W-1:0]    run_length_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [INDEX_W-1:0]  result_index_o;
  logic                bit_value_o;
  logic                cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]    cfg_wdata_i   = '0;

  request_t   request_q[$];
  reply_t     reply_q[$];
  logic [CAP-1:0] slot_map    = '0;
  logic [LEN_W-1:0] bits_in_use_q = BITS_IN_USE_RST;
  logic       req_fire    = 1'b0;
  logic       no_idle     = 1'b0;
  logic       stall_armed = 1'b0;
  int         stall_left  = 0;
  int         fail_count  = 0;
  int         cycle_count = 0;
  request_t   drive_req;
  request_t   seen_req;
  reply_t     got;
  reply_t     want;

  bitmap_contiguous_run_allocator_unit #(
    .CAPACITY_BITS(CAP),
    .WORD_BITS    (WORD_BITS_DEF)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .start_index_i (start_index_i),
    .run_length_i  (run_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .result_index_o(result_index_o),
    .bit_value_o   (bit_value_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int slot_bound();
    return (int'(bits_in_use_q) > CAP) ? CAP : int'(bits_in_use_q);
  endfunction

  // first-fit search and range marking on the private bitmap
  function automatic reply_t serve_request(request_t r);
    int     lim;
    int     k;
    int     j;
    int     run;
    reply_t rep;
    lim         = slot_bound();
    rep.status  = STAT_OK;
    rep.index   = r.start;
    rep.bit_val = 1'b0;
    if (int'(r.start) >= lim) begin
      rep.status = STAT_RANGE;
    end else if (r.op == OP_READ) begin
      rep.bit_val = slot_map[r.start];
    end else if (r.len == '0 || int'(r.len) > CAP) begin
      rep.status = STAT_RANGE;
    end else if (r.op == OP_ALLOC) begin
      rep.status = STAT_NO_RUN;
      run        = 0;
      for (k = int'(r.start); k < lim; k++) begin
        if (slot_map[k]) begin
          run = 0;
        end else begin
          run++;
          if (run == int'(r.len)) begin
            rep.status = STAT_OK;
            rep.index  = INDEX_W'(k + 1 - int'(r.len));
            for (j = k + 1 - int'(r.len); j <= k; j++) slot_map[j] = 1'b1;
            break;
          end
        end
      end
    end else begin
      for (k = int'(r.start); k < lim && k - int'(r.start) < int'(r.len); k++)
        slot_map[k] = (r.op == OP_SET);
    end
    return rep;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       lim;
    int       pick;
    lim  = slot_bound();
    pick = $urandom_range(99);
    if (pick < 40)      r.op = OP_ALLOC;
    else if (pick < 55) r.op = OP_SET;
    else if (pick < 78) r.op = OP_CLEAR;
    else                r.op = OP_READ;
    if (lim > 0 && $urandom_range(99) < 88) r.start = INDEX_W'($urandom_range(lim - 1));
    else r.start = INDEX_W'($urandom_range(CAP - 1));
    pick = $urandom_range(99);
    if (pick < 55)      r.len = LEN_W'($urandom_range(8, 1));
    else if (pick < 80) r.len = LEN_W'($urandom_range(64, 1));
    else if (pick < 88) r.len = LEN_W'($urandom_range(CAP, 65));
    else if (pick < 93) r.len = '0;
    else                r.len = LEN_W'($urandom_range(2047, CAP + 1));
    return r;
  endfunction

  task automatic queue_request(op_e op, int start, int len);
    request_t r;
    r.op    = op;
    r.start = INDEX_W'(start);
    r.len   = LEN_W'(len);
    request_q.push_back(r);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) request_q.push_back(random_request());
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || reply_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_bits_in_use(int value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= LEN_W'(value);
    bits_in_use_q = LEN_W'(value);
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_fire) begin
        if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= 13)) begin
          drive_req = request_q.pop_front();
          in_valid_i    <= 1'b1;
          opcode_i      <= drive_req.op;
          start_index_i <= drive_req.start;
          run_length_i  <= drive_req.len;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver with one long hold-off
  always @(negedge clk_i) begin
    if (stall_armed) begin
      stall_left  = HOLD_CYCLES;
      stall_armed = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.status  = status_e'(status_o);
        got.index   = result_index_o;
        got.bit_val = bit_value_o;
        if (reply_q.size() == 0) begin
          $display("%0t: result with no request open: status %0d index %0d bit %0d",
                   $time, got.status, got.index, got.bit_val);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.index != want.index) begin
            $display("%0t: result_index mismatch, expected %0d, actual %0d",
                     $time, want.index, got.index);
            fail_count++;
          end
          if (got.bit_val != want.bit_val) begin
            $display("%0t: bit_value mismatch, expected %0d, actual %0d",
                     $time, want.bit_val, got.bit_val);
            fail_count++;
          end
        end
      end
      req_fire = in_valid_i && in_ready_o;
      if (req_fire) begin
        seen_req.op    = op_e'(opcode_i);
        seen_req.start = start_index_i;
        seen_req.len   = run_length_i;
        reply_q.push_back(serve_request(seen_req));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full bitmap: fits, misses, bad lengths, clipped ranges
    queue_request(OP_READ,  0,    0);
    queue_request(OP_ALLOC, 0,    1);
    queue_request(OP_ALLOC, 0,    3);
    queue_request(OP_READ,  2,    2047);
    queue_request(OP_ALLOC, 0,    0);
    queue_request(OP_ALLOC, 0,    1025);
    queue_request(OP_SET,   10,   2047);
    queue_request(OP_SET,   1023, 1024);
    queue_request(OP_READ,  1023, 5);
    queue_request(OP_ALLOC, 1000, 100);
    queue_request(OP_CLEAR, 0,    1024);
    queue_request(OP_ALLOC, 0,    1024);
    queue_request(OP_CLEAR, 0,    1024);
    queue_request(OP_SET,   5,    1);
    queue_request(OP_ALLOC, 0,    10);
    queue_request(OP_ALLOC, 1023, 1);
    queue_request(OP_CLEAR, 0,    1024);

    // one slot managed
    write_bits_in_use(1);
    queue_request(OP_READ,  0, 1);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_ALLOC, 0, 1);
    queue_request(OP_ALLOC, 1, 1);
    queue_request(OP_CLEAR, 0, 2);

    // no slot managed: everything rejected
    write_bits_in_use(0);
    queue_request(OP_READ, 0, 1);
    queue_request(OP_SET,  0, 1);

    // register above capacity acts as full size
    write_bits_in_use(2047);
    queue_request(OP_ALLOC, 1020, 4);
    queue_request(OP_READ,  1023, 0);
    queue_request(OP_CLEAR, 1020, 4);

    write_bits_in_use(1024);
    stall_armed = 1'b1;
    queue_random(150);

    write_bits_in_use($urandom_range(1024, 1));
    no_idle = 1'b1;
    queue_random(120);
    wait_drained();
    no_idle = 1'b0;

    write_bits_in_use(64);
    queue_random(120);

    write_bits_in_use(2047);
    queue_random(100);

    write_bits_in_use($urandom_range(2047));
    queue_random(60);

    write_bits_in_use(1);
    queue_random(30);

    write_bits_in_use(0);
    queue_random(20);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && reply_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
